[sv/ising_spin_flip_acceptance_unit_assert.svh]
// assertion macros for the spin flip acceptance unit
`ifndef ISING_SPIN_FLIP_ACCEPTANCE_UNIT_ASSERT_SVH
`define ISING_SPIN_FLIP_ACCEPTANCE_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define ISFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define ISFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/isfa_pkg.sv]
// shared types, constants and helpers of the spin flip acceptance unit
package isfa_pkg;

  localparam int SPIN_COUNT_DEF = 16;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int POLY_ORDER_DEF = 8;
  localparam int MAX_SPINS      = 64;

  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 7;
  localparam int VALUE_W   = 40;
  localparam int CUTOFF_W  = 24;
  localparam int SCALE_W   = 48;
  localparam int PROB_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int PAIR_W    = 6;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 24'h80_0000;
  localparam logic [SCALE_W-1:0]  INV_RST    = 48'h0002_0000_0000;
  localparam logic [PROB_W-1:0]   PROB_ONE   = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CUTOFF = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_FIELD = 2'd0,
    CMD_LOAD_CPL   = 2'd1,
    CMD_LOAD_COEF  = 2'd2,
    CMD_EVAL       = 2'd3
  } cmd_t;

  // coefficient load word travelling down the pipeline in order
  typedef struct packed {
    logic                      vld;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
  } coef_ld_t;

  typedef struct packed {
    logic              ok;
    logic [PAIR_W-1:0] a;
    logic [PAIR_W-1:0] b;
  } pair_t;

  // packed upper-triangular slot to spin pair
  function automatic pair_t slot_pair(input logic [SLOT_W-1:0] s, input int n);
    pair_t p;
    int    base;
    p = '0;
    for (int a = 0; a < MAX_SPINS - 1; a++) begin
      if (a < n - 1) begin
        base = (a * (2 * n - a - 1)) >> 1;
        if (int'(s) >= base) begin
          p.a = PAIR_W'(a);
          p.b = PAIR_W'(int'(s) - base + a + 1);
        end
      end
    end
    p.ok = int'(s) < ((n * (n - 1)) >> 1);
    return p;
  endfunction

endpackage

[sv/isfa_ram.sv]
// generic single-port-write ram with registered read
module isfa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                 wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                 rdata
);

  logic [W-1:0] mem [0:D-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/isfa_tree.sv]
// local field adder tree and clipped energy change
module isfa_tree import isfa_pkg::*; #(
  parameter int SPIN_COUNT = SPIN_COUNT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic                        in_up,
  input  logic [SPIN_COUNT-1:0]       in_spins,
  input  logic                        in_fok,
  input  logic signed [FRAC_BITS:0]   in_field,
  input  logic [SPIN_COUNT-1:0]       in_cok,
  input  logic signed [FRAC_BITS:0]   in_cpl [SPIN_COUNT],
  input  coef_ld_t                    in_tok,
  output logic                        out_vld,
  output logic [FRAC_BITS-1:0]        out_delta,
  output coef_ld_t                    out_tok
);

  localparam int QW = FRAC_BITS + 1;
  localparam int NT = SPIN_COUNT + 1;
  localparam int L  = $clog2(NT);
  localparam logic signed [QW:0]   QMAX = {2'b00, {FRAC_BITS{1'b1}}};
  localparam logic signed [QW:0]   QMIN = {2'b11, {FRAC_BITS{1'b0}}};
  localparam logic signed [QW-1:0] QNEG = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [QW-1:0] QPOS = {1'b0, {FRAC_BITS{1'b1}}};

  function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s > QMAX) return QMAX[QW-1:0];
    if (s < QMIN) return QMIN[QW-1:0];
    return s[QW-1:0];
  endfunction

  function automatic logic signed [QW-1:0] sat_neg(input logic signed [QW-1:0] a);
    if (a == QNEG) return QPOS;
    return -a;
  endfunction

  logic signed [QW-1:0] lv [0:L][0:NT-1];
  logic                 vl [0:L];
  logic                 up [0:L];
  coef_ld_t             tk [0:L];
  logic signed [QW-1:0] fld;
  logic signed [QW-1:0] dbl;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0]     <= 1'b0;
      tk[0].vld <= 1'b0;
    end else begin
      vl[0] <= in_vld;
      tk[0] <= in_tok;
    end
    up[0]    <= in_up;
    lv[0][0] <= in_fok ? in_field : '0;
  end

  for (genvar j = 0; j < SPIN_COUNT; j++) begin : g_lane
    always_ff @(posedge clk) begin
      if (!in_cok[j]) begin
        lv[0][j+1] <= '0;
      end else if (in_spins[j]) begin
        lv[0][j+1] <= in_cpl[j];
      end else begin
        lv[0][j+1] <= sat_neg(in_cpl[j]);
      end
    end
  end

  for (genvar l = 1; l <= L; l++) begin : g_lvl
    localparam int CP = (NT + (1 << (l - 1)) - 1) >> (l - 1);
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[l]     <= 1'b0;
        tk[l].vld <= 1'b0;
      end else begin
        vl[l] <= vl[l-1];
        tk[l] <= tk[l-1];
      end
      up[l] <= up[l-1];
    end
    for (genvar k = 0; k < NT; k++) begin : g_node
      if (2 * k + 1 < CP) begin : g_add
        always_ff @(posedge clk) lv[l][k] <= sat_add(lv[l-1][2*k], lv[l-1][2*k+1]);
      end else if (2 * k < CP) begin : g_pass
        always_ff @(posedge clk) lv[l][k] <= lv[l-1][2*k];
      end else begin : g_zero
        always_ff @(posedge clk) lv[l][k] <= '0;
      end
    end
  end

  always_comb begin
    fld = up[L] ? lv[L][0] : sat_neg(lv[L][0]);
    dbl = sat_add(fld, fld);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld     <= 1'b0;
      out_tok.vld <= 1'b0;
    end else begin
      out_vld <= vl[L];
      out_tok <= tk[L];
    end
    out_delta <= dbl[QW-1] ? '0 : dbl[FRAC_BITS-1:0];
  end

endmodule

[sv/isfa_accept.sv]
// acceptance probability pipeline: scaling, clenshaw steps, clipping
module isfa_accept import isfa_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int POLY_ORDER = POLY_ORDER_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic [FRAC_BITS-1:0] in_delta,
  input  coef_ld_t             in_tok,
  input  logic [CUTOFF_W-1:0]  cutoff,
  input  logic [SCALE_W-1:0]   inv_cutoff,
  output logic                 out_vld,
  output logic [FRAC_BITS-1:0] out_delta,
  output logic [PROB_W-1:0]    out_prob
);

  localparam int PW  = VALUE_W;
  localparam int PPW = PW + 21;
  localparam int RW  = 45;
  localparam int S   = POLY_ORDER + 1;
  localparam int XSW = 33;
  localparam int HW  = SCALE_W / 2;
  localparam int MW  = XSW + HW;
  localparam int ZW  = XSW + SCALE_W;
  localparam int XW  = (FRAC_BITS > CUTOFF_W) ? FRAC_BITS : CUTOFF_W;
  localparam logic signed [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};

  typedef struct packed {
    logic                  vld;
    logic                  zero;
    logic                  over;
    logic [FRAC_BITS-1:0]  delta;
    logic signed [PW-1:0]  y;
    logic signed [PW-1:0]  b1;
    logic signed [PW-1:0]  b2;
    logic signed [PPW-1:0] ph;
    logic signed [PPW-1:0] pl;
    logic signed [RW-1:0]  r;
  } st_t;

  // front: flags and scaled x, split product, rounded z, chebyshev argument
  logic                 a0_vld, a0_zero, a0_over;
  logic [FRAC_BITS-1:0] a0_delta;
  logic [XSW-1:0]       a0_xs, xs_next;
  coef_ld_t             a0_tok;
  logic                 a1_vld, a1_zero, a1_over;
  logic [FRAC_BITS-1:0] a1_delta;
  logic [MW-1:0]        a1_plo, a1_phi;
  coef_ld_t             a1_tok;
  logic                 a2_vld, a2_zero, a2_over;
  logic [FRAC_BITS-1:0] a2_delta;
  logic [SCALE_W-1:0]   a2_z;
  coef_ld_t             a2_tok;
  logic [ZW-1:0]        zprod;
  logic [SCALE_W:0]     zr;
  logic [PW-1:0]        v40;
  logic signed [PW+1:0] y42;
  st_t                  e0_next;

  if (FRAC_BITS <= 32) begin : g_xs_up
    assign xs_next = XSW'(in_delta) << (32 - FRAC_BITS);
  end else begin : g_xs_dn
    localparam int SHF = FRAC_BITS - 32;
    localparam int FW1 = FRAC_BITS + 1;
    logic [FW1-1:0] xr;
    assign xr      = FW1'(in_delta) + (FW1'(1) << (SHF - 1));
    assign xs_next = XSW'(xr >> SHF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a0_vld <= 1'b0; a0_tok.vld <= 1'b0;
      a1_vld <= 1'b0; a1_tok.vld <= 1'b0;
      a2_vld <= 1'b0; a2_tok.vld <= 1'b0;
    end else begin
      a0_vld <= in_vld; a0_tok <= in_tok;
      a1_vld <= a0_vld; a1_tok <= a0_tok;
      a2_vld <= a1_vld; a2_tok <= a1_tok;
    end
    a0_zero  <= (in_delta == '0);
    a0_over  <= (XW'(in_delta) >= XW'(cutoff));
    a0_delta <= in_delta;
    a0_xs    <= xs_next;
    a1_zero  <= a0_zero;
    a1_over  <= a0_over;
    a1_delta <= a0_delta;
    a1_plo   <= MW'(a0_xs) * MW'(inv_cutoff[HW-1:0]);
    a1_phi   <= MW'(a0_xs) * MW'(inv_cutoff[SCALE_W-1:HW]);
    a2_zero  <= a1_zero;
    a2_over  <= a1_over;
    a2_delta <= a1_delta;
    a2_z     <= zr[SCALE_W] ? '1 : zr[SCALE_W-1:0];
  end

  always_comb begin
    zprod = (ZW'(a1_phi) << HW) + ZW'(a1_plo) + (ZW'(1) << 31);
    zr    = zprod[ZW-1:32];
  end

  always_comb begin
    v40 = (|a2_z[SCALE_W-1:35]) ? P_MAX : {1'b0, a2_z[34:0], 4'b0000};
    y42 = $signed({1'b0, v40, 1'b0}) - $signed({6'b000001, 36'b0});
    e0_next       = '0;
    e0_next.vld   = a2_vld;
    e0_next.zero  = a2_zero;
    e0_next.over  = a2_over;
    e0_next.delta = a2_delta;
    e0_next.y     = (y42 > $signed({2'b00, P_MAX})) ? P_MAX : y42[PW-1:0];
  end

  st_t                  e  [0:S];
  st_t                  ra [0:S-1];
  st_t                  rb [0:S-1];
  coef_ld_t             te [0:S];
  coef_ld_t             ta [0:S-1];
  coef_ld_t             tb [0:S-1];
  logic signed [PW-1:0] coef [0:S-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      e[0].vld  <= 1'b0;
      te[0].vld <= 1'b0;
    end else begin
      e[0]  <= e0_next;
      te[0] <= a2_tok;
    end
  end

  for (genvar s = 0; s < S; s++) begin : g_step
    localparam int K  = POLY_ORDER - s;
    localparam int SH = (K == 0) ? 36 : 35;
    localparam logic signed [2*PW:0] HALF = {{(2*PW+1-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
    logic signed [2*PW:0] prod;
    logic signed [2*PW:0] rnd;
    logic signed [RW+1:0] sum;
    logic signed [PW-1:0] b0;

    always_ff @(posedge clk) begin
      if (rst) begin
        ra[s].vld <= 1'b0;
        ta[s].vld <= 1'b0;
      end else begin
        ra[s]    <= e[s];
        ra[s].ph <= e[s].y * $signed(e[s].b1[PW-1:20]);
        ra[s].pl <= e[s].y * $signed({1'b0, e[s].b1[19:0]});
        ta[s]    <= te[s];
      end
    end

    always_comb begin
      prod = ({{20{ra[s].ph[PPW-1]}}, ra[s].ph} <<< 20) + {{20{ra[s].pl[PPW-1]}}, ra[s].pl};
      rnd  = prod + HALF;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rb[s].vld <= 1'b0;
        tb[s].vld <= 1'b0;
      end else begin
        rb[s]   <= ra[s];
        rb[s].r <= rnd[SH+RW-1:SH];
        tb[s]   <= ta[s];
      end
    end

    always_comb begin
      sum = {{2{rb[s].r[RW-1]}}, rb[s].r}
          - {{(RW+2-PW){rb[s].b2[PW-1]}}, rb[s].b2}
          + {{(RW+2-PW){coef[s][PW-1]}}, coef[s]};
      if (sum > $signed({{(RW+2-PW){1'b0}}, P_MAX})) begin
        b0 = P_MAX;
      end else if (sum < $signed({{(RW+2-PW){1'b1}}, P_MIN})) begin
        b0 = P_MIN;
      end else begin
        b0 = sum[PW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        e[s+1].vld  <= 1'b0;
        te[s+1].vld <= 1'b0;
      end else begin
        e[s+1]    <= rb[s];
        e[s+1].b2 <= rb[s].b1;
        e[s+1].b1 <= b0;
        te[s+1]   <= tb[s];
      end
    end

    // coefficient changes only between the words ahead of the load and behind it
    always_ff @(posedge clk) begin
      if (tb[s].vld && tb[s].slot == SLOT_W'(K)) begin
        coef[s] <= tb[s].value;
      end
    end
  end

  logic signed [PW:0] pr;
  logic [PROB_W-1:0]  prob_next;

  always_comb begin
    pr = {e[S].b1[PW-1], e[S].b1} + (PW+1)'(16);
    if (e[S].zero) begin
      prob_next = PROB_ONE;
    end else if (e[S].over || e[S].b1 <= 0) begin
      prob_next = '0;
    end else if (e[S].b1 >= $signed({4'b0001, 36'b0})) begin
      prob_next = PROB_ONE;
    end else begin
      prob_next = pr[36:5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= e[S].vld;
    end
    out_delta <= e[S].delta;
    out_prob  <= prob_next;
  end

endmodule

[sv/ising_spin_flip_acceptance_unit.sv]
// top level of the spin flip acceptance unit
// Takes one word per clock with no stall: loads of fields, couplings and
// coefficients, or evaluate words. An evaluate word gives one result, with
// done high for one cycle; a load gives none. Each result passes through the
// coupling adder tree, the scaling front and the chain of three-stage
// Clenshaw steps, each a split multiply, a rounding add and a saturating add.
// Loads take effect in word order, so a word sees every load accepted before
// it. busy is high only in reset. The receiver cannot hold a result off.
// Write cutoff registers only while no evaluate word is in flight.
module ising_spin_flip_acceptance_unit import isfa_pkg::*; #(
  parameter int SPIN_COUNT = SPIN_COUNT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int POLY_ORDER = POLY_ORDER_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [CMD_W-1:0]          cmd,
  input  logic [SLOT_W-1:0]         slot,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [SPIN_COUNT-1:0]     spins,
  input  logic [SPIN_COUNT-1:0]     flip_sel,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SCALE_W-1:0]        cfg_data,
  output logic                      done,
  output logic [FRAC_BITS-1:0]      delta_x,
  output logic [PROB_W-1:0]         acceptance
);

  localparam int IW = $clog2(SPIN_COUNT);
  localparam int QW = FRAC_BITS + 1;
  localparam logic signed [VALUE_W+1:0] VMAX =
    $signed({{(VALUE_W+1-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}});
  localparam logic signed [VALUE_W+1:0] VMIN =
    $signed({{(VALUE_W+2-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}});

  function automatic logic signed [QW-1:0] sat_q(input logic signed [VALUE_W-1:0] v);
    logic signed [VALUE_W+1:0] w;
    w = {{2{v[VALUE_W-1]}}, v};
    if (w > VMAX) return VMAX[QW-1:0];
    if (w < VMIN) return VMIN[QW-1:0];
    return w[QW-1:0];
  endfunction

  logic                  acc;
  logic [CUTOFF_W-1:0]   cutoff;
  logic [SCALE_W-1:0]    inv_cutoff;
  pair_t                 pr;
  logic [IW-1:0]         hi, hi2;
  logic                  fld_we;
  logic signed [QW-1:0]  ld_q;
  logic signed [QW-1:0]  fld_rd;
  logic signed [QW-1:0]  cpl_rd [SPIN_COUNT];
  logic [SPIN_COUNT-1:0] cok_next;

  logic                  s1_vld;
  logic                  s1_up;
  logic                  s1_fok;
  logic [SPIN_COUNT-1:0] s1_spins;
  logic [SPIN_COUNT-1:0] s1_cok;
  coef_ld_t              s1_tok;
  coef_ld_t              tok_next;

  logic                  t_vld;
  logic [FRAC_BITS-1:0]  t_delta;
  coef_ld_t              t_tok;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff     <= CUTOFF_RST;
      inv_cutoff <= INV_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CUTOFF:     cutoff     <= cfg_data[CUTOFF_W-1:0];
        CFG_INV_CUTOFF: inv_cutoff <= cfg_data;
        default:        ;
      endcase
    end
  end

  // highest selected spin, and the next one down for its own lane
  always_comb begin
    hi  = '0;
    hi2 = '0;
    for (int i = 0; i < SPIN_COUNT; i++) begin
      if (flip_sel[i]) hi = IW'(i);
    end
    for (int i = 0; i < SPIN_COUNT; i++) begin
      if (flip_sel[i] && IW'(i) != hi) hi2 = IW'(i);
    end
  end

  assign pr     = slot_pair(slot, SPIN_COUNT);
  assign ld_q   = sat_q(value);
  assign fld_we = acc && cmd == CMD_LOAD_FIELD && int'(slot) < SPIN_COUNT;

  isfa_ram #(.W(QW), .D(SPIN_COUNT)) u_field (
    .clk   (clk),
    .we    (fld_we),
    .waddr (slot[IW-1:0]),
    .wdata (ld_q),
    .raddr (hi),
    .rdata (fld_rd)
  );

  // coupling row of each neighbour, written at both ends of the pair
  for (genvar j = 0; j < SPIN_COUNT; j++) begin : g_cpl
    logic                  we;
    logic [IW-1:0]         waddr;
    logic [IW-1:0]         raddr;
    logic [SPIN_COUNT-1:0] others;

    always_comb begin
      we        = acc && cmd == CMD_LOAD_CPL && pr.ok
                  && (pr.a == PAIR_W'(j) || pr.b == PAIR_W'(j));
      waddr     = (pr.a == PAIR_W'(j)) ? pr.b[IW-1:0] : pr.a[IW-1:0];
      raddr     = (hi == IW'(j)) ? hi2 : hi;
      others    = flip_sel;
      others[j] = 1'b0;
    end

    assign cok_next[j] = |others;

    isfa_ram #(.W(QW), .D(SPIN_COUNT)) u_row (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (ld_q),
      .raddr (raddr),
      .rdata (cpl_rd[j])
    );
  end

  always_comb begin
    tok_next.vld   = acc && cmd == CMD_LOAD_COEF;
    tok_next.slot  = slot;
    tok_next.value = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld     <= 1'b0;
      s1_tok.vld <= 1'b0;
    end else begin
      s1_vld <= acc && cmd == CMD_EVAL;
      s1_tok <= tok_next;
    end
    s1_up    <= |(spins & flip_sel);
    s1_fok   <= |flip_sel;
    s1_spins <= spins;
    s1_cok   <= cok_next;
  end

  isfa_tree #(.SPIN_COUNT(SPIN_COUNT), .FRAC_BITS(FRAC_BITS)) u_tree (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (s1_vld),
    .in_up     (s1_up),
    .in_spins  (s1_spins),
    .in_fok    (s1_fok),
    .in_field  (fld_rd),
    .in_cok    (s1_cok),
    .in_cpl    (cpl_rd),
    .in_tok    (s1_tok),
    .out_vld   (t_vld),
    .out_delta (t_delta),
    .out_tok   (t_tok)
  );

  isfa_accept #(.FRAC_BITS(FRAC_BITS), .POLY_ORDER(POLY_ORDER)) u_accept (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (t_vld),
    .in_delta   (t_delta),
    .in_tok     (t_tok),
    .cutoff     (cutoff),
    .inv_cutoff (inv_cutoff),
    .out_vld    (done),
    .out_delta  (delta_x),
    .out_prob   (acceptance)
  );

endmodule

[sv/isfa_checker.sv]
// port-level checks of the spin flip acceptance unit, bound to the top level
`include "ising_spin_flip_acceptance_unit_assert.svh"

module isfa_checker import isfa_pkg::*; #(
  parameter int SPIN_COUNT = SPIN_COUNT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int POLY_ORDER = POLY_ORDER_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [CMD_W-1:0]     cmd,
  input logic                 done,
  input logic [FRAC_BITS-1:0] delta_x,
  input logic [PROB_W-1:0]    acceptance
);

  localparam int LAT = 8 + $clog2(SPIN_COUNT + 1) + 3 * (POLY_ORDER + 1);

  `ISFA_ASSERT_IMP(a_prob_range, done, acceptance <= PROB_ONE, "probability above one")
  `ISFA_ASSERT_IMP(a_zero_one, done && delta_x == '0, acceptance == PROB_ONE, "zero change not one")
  `ISFA_ASSERT_IMP(a_done_src, done, $past(start && !busy && cmd == CMD_EVAL, LAT), "result without evaluate word")
  `ISFA_ASSERT_NXT(a_rst_quiet, rst, !done, "result right after reset")

endmodule

bind ising_spin_flip_acceptance_unit isfa_checker #(
  .SPIN_COUNT (SPIN_COUNT),
  .FRAC_BITS  (FRAC_BITS),
  .POLY_ORDER (POLY_ORDER)
) u_isfa_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .cmd        (cmd),
  .done       (done),
  .delta_x    (delta_x),
  .acceptance (acceptance)
);
